### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the stochastic oscillator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define MSO_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mso assertion failed");

// Antecedent at one edge implies the consequent at the same edge.
`define MSO_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mso implication failed");

`endif

### hdl/mso_pkg.sv
// Package of the stochastic oscillator: types, reset constants and saturation helpers.
package mso_pkg;

  localparam int MAX_WINDOW_DEF = 64;

  localparam logic [6:0]         WINDOW_RST     = 7'd20;
  localparam logic signed [31:0] HP_GAIN_RST    = 32'sd980805175;
  localparam logic signed [31:0] HP_FB1_RST     = 32'sd1957403128;
  localparam logic signed [31:0] HP_FB2_RST     = -32'sd892074371;
  localparam logic signed [31:0] SM_GAIN_RST    = 32'sd271784457;
  localparam logic signed [31:0] SM_FB1_RST     = 32'sd1243590601;
  localparam logic signed [31:0] SM_FB2_RST     = -32'sd441633234;

  // Configuration register indexes
  localparam logic [2:0] CFG_WINDOW  = 3'd0;
  localparam logic [2:0] CFG_HP_GAIN = 3'd1;
  localparam logic [2:0] CFG_HP_FB1  = 3'd2;
  localparam logic [2:0] CFG_HP_FB2  = 3'd3;
  localparam logic [2:0] CFG_SM_GAIN = 3'd4;
  localparam logic [2:0] CFG_SM_FB1  = 3'd5;
  localparam logic [2:0] CFG_SM_FB2  = 3'd6;

  localparam logic signed [63:0] S48_MAX_64 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] S48_MIN_64 = 64'shFFFF_8000_0000_0000;
  localparam logic signed [63:0] S32_MAX_64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN_64 = 64'shFFFF_FFFF_8000_0000;

  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

  // Request to the rounding multiplier
  typedef struct packed {
    logic               start;
    logic               half;   // divide by 2^31 instead of 2^30
    logic signed [31:0] coef;
    logic signed [63:0] x;
  } mul_req_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MSTART = 8'b0000_0010,
    S_MWAIT  = 8'b0000_0100,
    S_WIN    = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_DPREP  = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_LO   = 4'b0010,
    P_HI   = 4'b0100,
    P_SUM  = 4'b1000
  } mul_phase_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > S48_MAX_64) r = S48_MAX;
    else if (v < S48_MIN_64) r = S48_MIN;
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX_64) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN_64) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### hdl/mso_mul.sv
// Rounding multiplier: coef * x / 2^30 (or 2^31), half up, over two 32-bit partial products.
module mso_mul import mso_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  output logic               done,
  output logic signed [63:0] term
);

  mul_phase_t         ph;
  logic signed [31:0] c;
  logic signed [63:0] xv;
  logic               half;
  logic signed [64:0] plo;
  logic signed [64:0] phi;
  logic signed [32:0] b;
  logic signed [64:0] prod;
  logic signed [96:0] sum;
  logic signed [96:0] rnd;

  // One shared multiplier: low half unsigned, then high half signed
  always_comb begin
    b    = (ph == P_LO) ? $signed({1'b0, xv[31:0]}) : $signed({xv[63], xv[63:32]});
    prod = c * b;
    rnd  = half ? (97'sd1 <<< 30) : (97'sd1 <<< 29);
    sum  = $signed({phi, 32'b0}) + $signed({{32{plo[64]}}, plo}) + rnd;
  end

  // Phase control
  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph)
        P_IDLE: if (req.start) ph <= P_LO;
        P_LO:   ph <= P_HI;
        P_HI:   ph <= P_SUM;
        P_SUM: begin
          ph   <= P_IDLE;
          done <= 1'b1;
        end
        default: ph <= P_IDLE;
      endcase
    end
  end

  // Operands and partial products
  always_ff @(posedge clk) begin
    if (ph == P_IDLE && req.start) begin
      c    <= req.coef;
      xv   <= req.x;
      half <= req.half;
    end
    if (ph == P_LO) plo <= prod;
    if (ph == P_HI) phi <= prod;
    if (ph == P_SUM) term <= half ? sum[94:31] : sum[93:30];
  end

endmodule

### hdl/mesa_stochastic_oscillator.sv
// Top level of the MESA stochastic oscillator: filters, window tracking, divide and output.
//
// One price per input transaction. The first two samples only load the price
// history. Each later sample runs six rounded multiplies through one shared
// multi-cycle multiplier, writes the smoothed value into a circular window
// memory, and when a held extreme ages out rescans the newest
// min(window_length, samples) entries through the memory's registered read
// port at one entry a cycle. Once window_length+2 earlier samples have been
// seen, a 30-step restoring divide (skipped when the quotient saturates or is
// zero) and three more multiplies produce one result transaction. The next
// sample is taken while a result still waits on the output register.
module mesa_stochastic_oscillator import mso_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] price_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] stoch_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_WINDOW + 1);
  localparam int WW = $clog2(MAX_WINDOW + 3);
  localparam int MA = $clog2(MAX_WINDOW);

  // Configuration
  logic [6:0]         window_length;
  logic signed [31:0] hp_gain, hp_fb1, hp_fb2, sm_gain, sm_fb1, sm_fb2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RST;
      hp_gain <= HP_GAIN_RST;
      hp_fb1  <= HP_FB1_RST;
      hp_fb2  <= HP_FB2_RST;
      sm_gain <= SM_GAIN_RST;
      sm_fb1  <= SM_FB1_RST;
      sm_fb2  <= SM_FB2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW:  window_length <= cfg_data[6:0];
        CFG_HP_GAIN: hp_gain <= cfg_data;
        CFG_HP_FB1:  hp_fb1  <= cfg_data;
        CFG_HP_FB2:  hp_fb2  <= cfg_data;
        CFG_SM_GAIN: sm_gain <= cfg_data;
        CFG_SM_FB1:  sm_fb1  <= cfg_data;
        CFG_SM_FB2:  sm_fb2  <= cfg_data;
        default: ;
      endcase
    end
  end

  // State
  state_t             state;
  logic signed [31:0] ph0, ph1, p_cur;
  logic signed [33:0] diff;
  logic signed [47:0] hh0, hh1, sh0, sh1, hp, sm;
  logic signed [47:0] win_high, win_low, best_hi, best_lo;
  logic [AW-1:0]      high_age, low_age, at_hi, at_lo;
  logic [WW-1:0]      warm;
  logic signed [31:0] stoch_prev, oh0, oh1, res;
  logic signed [31:0] st;
  logic [3:0]         tsel;
  logic signed [63:0] acc;
  logic               emit, scan_hi, scan_lo;
  logic [MA-1:0]      head;
  logic [AW-1:0]      rk, rd_k, scan_n;
  logic               rd_valid;
  logic signed [49:0] rem;
  logic signed [48:0] den;
  logic [4:0]         dcnt;

  // Window memory
  logic signed [47:0] win_mem [MAX_WINDOW];
  logic               mem_we;
  logic [MA-1:0]      mem_wa, mem_ra;
  logic signed [47:0] mem_rd;

  always_ff @(posedge clk) begin
    if (mem_we) win_mem[mem_wa] <= sm;
    mem_rd <= win_mem[mem_ra];
  end

  // Multiplier
  mul_req_t           mreq;
  logic               mdone;
  logic signed [63:0] mterm;

  mso_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .term(mterm));

  // Effective window, warm-up and address arithmetic
  logic [AW-1:0]      w, n_next, ha_inc, la_inc;
  logic [WW-1:0]      warm_inc;
  logic [MA-1:0]      head_new;
  logic signed [63:0] acc_sum;
  logic signed [47:0] bh_next, bl_next;
  logic [AW-1:0]      ah_next, al_next;
  logic signed [48:0] num_c, den_c;
  logic signed [49:0] rem2;
  int                 n_tmp;

  always_comb begin
    if (window_length == 7'd0) w = AW'(1);
    else if (32'(window_length) > MAX_WINDOW) w = AW'(MAX_WINDOW);
    else w = AW'(window_length);
    warm_inc = (32'(warm) < MAX_WINDOW + 2) ? warm + WW'(1) : warm;
    n_tmp    = 32'(warm_inc) - 2;
    n_next   = (n_tmp > 32'(w)) ? w : AW'(n_tmp);
    ha_inc   = (32'(high_age) < MAX_WINDOW) ? high_age + AW'(1) : high_age;
    la_inc   = (32'(low_age) < MAX_WINDOW) ? low_age + AW'(1) : low_age;
    head_new = (32'(head) == MAX_WINDOW - 1) ? '0 : head + MA'(1);
    if (32'(head) >= 32'(rk)) mem_ra = MA'(32'(head) - 32'(rk));
    else mem_ra = MA'(32'(head) + MAX_WINDOW - 32'(rk));
    mem_we   = (state == S_WIN);
    mem_wa   = head_new;
    acc_sum  = acc + mterm;
    // Scan compare; the newest entry wins a tie
    bh_next = best_hi; ah_next = at_hi;
    bl_next = best_lo; al_next = at_lo;
    if (rd_k == '0 || mem_rd > best_hi) begin bh_next = mem_rd; ah_next = rd_k; end
    if (rd_k == '0 || mem_rd < best_lo) begin bl_next = mem_rd; al_next = rd_k; end
    num_c = 49'(sm) - 49'(win_low);
    den_c = 49'(win_high) - 49'(win_low);
    rem2  = rem <<< 1;
  end

  // Operand select for the multiplier
  always_comb begin
    mreq.start = (state == S_MSTART);
    mreq.half  = (tsel == 4'd3) || (tsel == 4'd6);
    case (tsel)
      4'd0: begin mreq.coef = hp_gain; mreq.x = 64'(diff); end
      4'd1: begin mreq.coef = hp_fb1;  mreq.x = 64'(hh0); end
      4'd2: begin mreq.coef = hp_fb2;  mreq.x = 64'(hh1); end
      4'd3: begin mreq.coef = sm_gain; mreq.x = 64'(hp) + 64'(hh0); end
      4'd4: begin mreq.coef = sm_fb1;  mreq.x = 64'(sh0); end
      4'd5: begin mreq.coef = sm_fb2;  mreq.x = 64'(sh1); end
      4'd6: begin mreq.coef = sm_gain; mreq.x = 64'(st) + 64'(stoch_prev); end
      4'd7: begin mreq.coef = sm_fb1;  mreq.x = 64'(oh0); end
      4'd8: begin mreq.coef = sm_fb2;  mreq.x = 64'(oh1); end
      default: begin mreq.coef = '0; mreq.x = '0; end
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ph0 <= '0; ph1 <= '0;
      hh0 <= '0; hh1 <= '0;
      sh0 <= '0; sh1 <= '0;
      win_high   <= S48_MIN;
      win_low    <= S48_MAX;
      high_age   <= '0;
      low_age    <= '0;
      stoch_prev <= '0;
      oh0 <= '0; oh1 <= '0;
      warm       <= '0;
      head       <= '0;
      rd_valid   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // output register drains; a new result in S_OUT reloads it instead
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          if (32'(warm) < 2) begin
            ph1  <= ph0;
            ph0  <= s_axis_tdata;
            warm <= warm + WW'(1);
          end else begin
            p_cur <= s_axis_tdata;
            diff  <= 34'($signed(s_axis_tdata)) - (34'(ph0) <<< 1) + 34'(ph1);
            tsel  <= 4'd0;
            acc   <= '0;
            state <= S_MSTART;
          end
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: if (mdone) begin
          tsel <= tsel + 4'd1;
          acc  <= acc_sum;
          state <= S_MSTART;
          case (tsel)
            4'd2: begin hp <= sat48(acc_sum); acc <= '0; end
            4'd5: begin sm <= sat48(acc_sum); acc <= '0; state <= S_WIN; end
            4'd8: begin
              res <= sat32(acc_sum);
              stoch_prev <= st;
              oh1 <= oh0;
              oh0 <= sat32(acc_sum);
              state <= S_OUT;
            end
            default: ;
          endcase
        end
        S_WIN: begin
          ph1 <= ph0; ph0 <= p_cur;
          hh1 <= hh0; hh0 <= hp;
          sh1 <= sh0; sh0 <= sm;
          head   <= head_new;
          emit   <= 32'(warm) >= 32'(w) + 2;
          warm   <= warm_inc;
          scan_n <= n_next;
          scan_hi <= 1'b0;
          scan_lo <= 1'b0;
          rk <= '0;
          rd_valid <= 1'b0;
          if (sm >= win_high) begin
            win_high <= sm; high_age <= '0;
          end else begin
            high_age <= ha_inc;
            scan_hi  <= ha_inc >= w;
          end
          if (sm <= win_low) begin
            win_low <= sm; low_age <= '0;
          end else begin
            low_age <= la_inc;
            scan_lo <= la_inc >= w;
          end
          if ((sm < win_high && ha_inc >= w) || (sm > win_low && la_inc >= w))
            state <= S_SCAN;
          else if (32'(warm) >= 32'(w) + 2)
            state <= S_DPREP;
          else
            state <= S_IDLE;
        end
        S_SCAN: begin
          rd_valid <= rk < scan_n;
          rd_k     <= rk;
          if (rk < scan_n) rk <= rk + AW'(1);
          if (rd_valid) begin
            best_hi <= bh_next; at_hi <= ah_next;
            best_lo <= bl_next; at_lo <= al_next;
            if (rd_k == scan_n - AW'(1)) begin
              if (scan_hi) begin win_high <= bh_next; high_age <= ah_next; end
              if (scan_lo) begin win_low <= bl_next; low_age <= al_next; end
              rd_valid <= 1'b0;
              state <= emit ? S_DPREP : S_IDLE;
            end
          end
        end
        S_DPREP: begin
          tsel <= 4'd6;
          acc  <= '0;
          den  <= den_c;
          rem  <= 50'(num_c);
          st   <= '0;
          dcnt <= 5'd30;
          if (num_c <= 0 || den_c <= 0) state <= S_MSTART;
          else if (num_c >= den_c) begin
            st <= 32'sd1 <<< 30;
            state <= S_MSTART;
          end else state <= S_DIV;
        end
        S_DIV: begin
          if (rem2 >= 50'(den)) begin
            rem <= rem2 - 50'(den);
            st  <= (st <<< 1) | 32'sd1;
          end else begin
            rem <= rem2;
            st  <= st <<< 1;
          end
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd1) state <= S_MSTART;
        end
        S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata  <= res;
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `MSO_ASSERT_IMP(a_done_in_wait, clk, rst, mdone, state == S_MWAIT)
  `MSO_ASSERT_IMP(a_scan_in_range, clk, rst, rd_valid, rd_k < scan_n)
  `MSO_ASSERT_IMP(a_low_le_high, clk, rst, state == S_IDLE && 32'(warm) > 2, win_low <= win_high)

endmodule
